// ===== sv/swmm_pkg.sv =====
// Shared types, constants and a helper function of the sliding-window minimum and maximum block.
`default_nettype none
package swmm_pkg;

  localparam int WindowMax = 1024;
  localparam int PosW      = $clog2(WindowMax);
  localparam int KW        = PosW + 1;
  localparam int CfgW      = 11;
  localparam int DataW     = 32;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic [PosW-1:0]         pos;
  } entry_t;

  typedef struct packed {
    logic                    start;
    logic                    push;
    logic                    clear;
    logic signed [DataW-1:0] sample;
    logic [PosW-1:0]         pos;
    logic [KW-1:0]           win;
  } deq_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] front;
  } deq_sts_t;

  function automatic logic [KW-1:0] clamp_win(input logic [CfgW-1:0] k);
    logic [KW-1:0] r;
    if (k == '0) begin
      r = KW'(1);
    end else if (int'(k) > WindowMax) begin
      r = KW'(WindowMax);
    end else begin
      r = KW'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sliding_window_min_max_top.sv =====
// Top level of the sliding-window minimum and maximum block: handshakes, sequence control.
`default_nettype none
// Each sample runs through expiry of the front candidate, the pop loop and the push, and waits
// for the longer of the two pop runs; a new sample is stalled until the current one is pushed,
// and a sample that gives a result waits further while the previous result is still held in
// the output register; the minimum and maximum queues each live in a two-read-port RAM with
// registered reads, and the pop loop re-reads the queue tail once per dropped candidate. The
// window size is latched at the first sample of a sequence, a sample flagged as last gives its
// result if the window is full and then clears the sequence; the RAMs need no clearing pass.
module sliding_window_min_max_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [swmm_pkg::CfgW-1:0]               cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [swmm_pkg::DataW-1:0]       sample_i,
  input  wire logic                                    last_sample_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [swmm_pkg::DataW-1:0]            window_min_o,
  output logic signed [swmm_pkg::DataW-1:0]            window_max_o
);
  import swmm_pkg::*;

  typedef enum logic {T_IDLE, T_RUN} tstate_e;

  tstate_e                 state_q;
  logic [CfgW-1:0]         window_size_q;
  logic signed [DataW-1:0] sample_q;
  logic                    last_q;
  logic [PosW-1:0]         pos_q;
  logic [PosW-1:0]         wp_q;
  logic [KW-1:0]           k_q;
  logic [KW-1:0]           seen_q;
  logic [KW-1:0]           seen_next;
  logic                    out_valid_q;
  logic signed [DataW-1:0] min_q, max_q;

  logic                    accept, produce, room, push;
  deq_cmd_t                cmd;
  deq_sts_t                sts_min, sts_max;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != T_IDLE);
  assign accept      = in_valid_i && (state_q == T_IDLE);
  assign seen_next   = (seen_q < k_q) ? seen_q + KW'(1) : seen_q;
  assign produce     = (seen_next >= k_q);
  assign room        = !out_valid_q || !out_stall_i;
  assign push        = (state_q == T_RUN) && sts_min.done && sts_max.done
                       && (!produce || room);

  assign cmd.start  = accept;
  assign cmd.push   = push;
  assign cmd.clear  = push && last_q;
  assign cmd.sample = sample_q;
  assign cmd.pos    = pos_q;
  assign cmd.win    = k_q;

  swmm_deque u_min (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b0),
    .cmd_i    (cmd),
    .sts_o    (sts_min)
  );

  swmm_deque u_max (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b1),
    .cmd_i    (cmd),
    .sts_o    (sts_max)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      window_size_q <= CfgW'(1);
      sample_q      <= '0;
      last_q        <= 1'b0;
      pos_q         <= '0;
      wp_q          <= '0;
      k_q           <= KW'(1);
      seen_q        <= '0;
      out_valid_q   <= 1'b0;
      min_q         <= '0;
      max_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        window_size_q <= cfg_data_i;
      end
      if (push && produce) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (accept) begin
            sample_q <= sample_i;
            last_q   <= last_sample_i;
            pos_q    <= wp_q;
            if (seen_q == '0) begin
              k_q <= clamp_win(window_size_q);
            end
            state_q <= T_RUN;
          end
        end
        T_RUN: begin
          if (push) begin
            if (produce) begin
              min_q       <= sts_min.front;
              max_q       <= sts_max.front;
            end
            if (last_q) begin
              seen_q <= '0;
              wp_q   <= '0;
            end else begin
              seen_q <= seen_next;
              wp_q   <= wp_q + PosW'(1);
            end
            state_q <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = min_q;
  assign window_max_o = max_q;

endmodule
`default_nettype wire

// ===== sv/swmm_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none
module swmm_ram #(
  parameter int Width = 42,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic      [Width-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/swmm_deque.sv =====
// Monotonic candidate queue kept in a RAM ring, for either the minimum or the maximum.
`default_nettype none
module swmm_deque (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              is_max_i,
  input  wire swmm_pkg::deq_cmd_t cmd_i,
  output swmm_pkg::deq_sts_t     sts_o
);
  import swmm_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_EXP, D_POP, D_DONE} dstate_e;

  dstate_e         state_q, state_d;
  logic [PosW-1:0] head_q, head_d;
  logic [KW-1:0]   cnt_q, cnt_d;

  entry_t          rd_a, rd_b, wr_entry;
  logic            re_a, re_b;
  logic [PosW-1:0] raddr_a, raddr_b, waddr;

  logic            expire;
  logic [KW-1:0]   cnt_e;
  logic [PosW-1:0] head_e;
  logic            pop;

  function automatic logic beaten(input logic is_max, input logic signed [DataW-1:0] back,
                                  input logic signed [DataW-1:0] s);
    logic r;
    r = is_max ? (back <= s) : (back >= s);
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = head_q;
    raddr_b = head_q + cnt_q[PosW-1:0] - PosW'(1);
    expire  = 1'b0;
    cnt_e   = cnt_q;
    head_e  = head_q;
    pop     = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (cmd_i.start) begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          state_d = D_EXP;
        end
      end
      D_EXP: begin
        expire  = (cnt_q != '0) && (PosW'(cmd_i.pos - rd_a.pos) == cmd_i.win[PosW-1:0]);
        cnt_e   = cnt_q - KW'(expire);
        head_e  = head_q + PosW'(expire);
        pop     = (cnt_e != '0) && beaten(is_max_i, rd_b.val, cmd_i.sample);
        cnt_d   = cnt_e - KW'(pop);
        head_d  = head_e;
        re_a    = 1'b1;
        raddr_a = head_e;
        re_b    = pop;
        raddr_b = head_e + cnt_d[PosW-1:0] - PosW'(1);
        state_d = pop ? D_POP : D_DONE;
      end
      D_POP: begin
        pop     = (cnt_q != '0) && beaten(is_max_i, rd_b.val, cmd_i.sample);
        cnt_d   = cnt_q - KW'(pop);
        re_b    = pop;
        raddr_b = head_q + cnt_d[PosW-1:0] - PosW'(1);
        state_d = pop ? D_POP : D_DONE;
      end
      D_DONE: begin
        if (cmd_i.push) begin
          cnt_d   = cnt_q + KW'(1);
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
    if (cmd_i.clear) begin
      head_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  assign waddr        = head_q + cnt_q[PosW-1:0];
  assign wr_entry.val = cmd_i.sample;
  assign wr_entry.pos = cmd_i.pos;

  swmm_ram #(
    .Width($bits(entry_t)),
    .Depth(WindowMax)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.push),
    .waddr_i   (waddr),
    .wdata_i   (wr_entry),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  assign sts_o.done  = (state_q == D_DONE);
  assign sts_o.front = (cnt_q == '0) ? cmd_i.sample : rd_a.val;

`ifndef SYNTHESIS
  a_push_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> state_q == D_DONE)
    else $error("Candidate pushed before the queue had settled.");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cmd_i.clear) |=> cnt_q == $past(cnt_q) + KW'(1))
    else $error("Push did not grow the queue by one.");
  a_within_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_DONE |-> cnt_q < cmd_i.win)
    else $error("Queue holds more candidates than the window allows.");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> state_q == D_IDLE)
    else $error("New transaction started while the queue was busy.");
`endif

endmodule
`default_nettype wire

// ===== dv/sliding_window_min_max_top_tb.sv =====
// Self-checking testbench for the sliding-window minimum and maximum block.
module sliding_window_min_max_top_tb;
  import swmm_pkg::*;

  localparam int StuckLimit  = 20000;
  localparam int DrainCycles = 1200;
  localparam int LongHold    = 400;
  localparam logic signed [DataW-1:0] MinSample = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] MaxSample = {1'b0, {(DataW-1){1'b1}}};

  typedef enum int {PatRandom, PatTies, PatRising, PatFalling, PatExtreme} pattern_e;

  typedef struct {
    logic signed [DataW-1:0] lo;
    logic signed [DataW-1:0] hi;
  } extremes_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgW-1:0]         cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic signed [DataW-1:0] sample_i      = '0;
  logic                    last_sample_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic signed [DataW-1:0] window_min_o;
  logic signed [DataW-1:0] window_max_o;

  sliding_window_min_max_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .window_min_o  (window_min_o),
    .window_max_o  (window_max_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic signed [DataW-1:0] ring_samples [WindowMax];
  logic [CfgW-1:0]         window_reg   = CfgW'(1);
  int                      ring_wr_pos  = 0;
  int                      seq_seen     = 0;
  int                      seq_window   = 1;
  extremes_t               expected_extremes [$];

  int  n_errors      = 0;
  bit  idle_en       = 1'b1;
  bit  long_hold_req = 1'b0;

  function automatic void predict_window_extremes(input logic signed [DataW-1:0] s,
                                                  input logic last);
    extremes_t r;
    int        j;
    int        idx;
    if (seq_seen == 0) begin
      if (window_reg == '0) begin
        seq_window = 1;
      end else if (int'(window_reg) > WindowMax) begin
        seq_window = WindowMax;
      end else begin
        seq_window = int'(window_reg);
      end
    end
    ring_samples[ring_wr_pos] = s;
    ring_wr_pos = (ring_wr_pos + 1 >= WindowMax) ? 0 : ring_wr_pos + 1;
    if (seq_seen < seq_window) seq_seen++;
    if (seq_seen >= seq_window) begin
      r.lo = MaxSample;
      r.hi = MinSample;
      for (j = 1; j <= seq_window; j++) begin
        idx = (ring_wr_pos + WindowMax - j) % WindowMax;
        if (ring_samples[idx] < r.lo) r.lo = ring_samples[idx];
        if (ring_samples[idx] > r.hi) r.hi = ring_samples[idx];
      end
      expected_extremes = {expected_extremes, r};
    end
    if (last) begin
      seq_seen    = 0;
      ring_wr_pos = 0;
    end
  endfunction

  task automatic send_sample(input logic signed [DataW-1:0] s, input logic last);
    bit taken;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_sample_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_window_extremes(s, last);
  endtask

  task automatic send_sequence(input int len, input bit close);
    pattern_e                pat;
    logic signed [DataW-1:0] base;
    logic signed [DataW-1:0] step;
    logic signed [DataW-1:0] s;
    int                      i;
    pat  = pattern_e'($urandom_range(0, 4));
    base = $urandom;
    step = $urandom_range(1, 5000);
    for (i = 0; i < len; i++) begin
      case (pat)
        PatTies: begin
          s = $signed($urandom_range(0, 6)) - 3;
        end
        PatRising: begin
          s = base + step * i;
        end
        PatFalling: begin
          s = base - step * i;
        end
        PatExtreme: begin
          case ($urandom_range(0, 3))
            0: s = MinSample;
            1: s = MaxSample;
            2: s = MinSample + 1;
            default: s = MaxSample - 1;
          endcase
        end
        default: begin
          s = $urandom;
        end
      endcase
      send_sample(s, close && (i == len - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_extremes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [CfgW-1:0] k);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    window_reg = k;
  endtask

  task automatic test_extremes();
    send_sample(MinSample, 1'b0);
    send_sample(MaxSample, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-1, 1'b1);
    wait_drained();
    write_window(CfgW'(3));
    send_sample(MaxSample, 1'b0);
    send_sample(MinSample, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample('0, 1'b1);
  endtask

  task automatic test_short_sequence();
    wait_drained();
    write_window(CfgW'(4));
    send_sample(7, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(MaxSample, 1'b1);
    send_sample(MinSample, 1'b1);
  endtask

  task automatic test_zero_window();
    wait_drained();
    write_window('0);
    send_sample(11, 1'b0);
    send_sample(-11, 1'b0);
    send_sample(3, 1'b1);
  endtask

  task automatic test_midsequence_write();
    wait_drained();
    write_window(CfgW'(2));
    send_sample(100, 1'b0);
    send_sample(-100, 1'b0);
    send_sample(50, 1'b0);
    wait_drained();
    write_window(CfgW'(5));
    send_sample(-50, 1'b0);
    send_sample(20, 1'b0);
    send_sample(30, 1'b1);
    send_sequence(6, 1'b1);
  endtask

  task automatic test_full_window();
    logic signed [DataW-1:0] s;
    int                      i;
    wait_drained();
    write_window({CfgW{1'b1}});
    send_sequence(20, 1'b1);
    wait_drained();
    write_window(CfgW'(300));
    for (i = 0; i < 304; i++) begin
      if (i < 120) begin
        s = MaxSample - 1000 * i;
      end else if (i < 240) begin
        s = MinSample + 1000 * i;
      end else begin
        s = $urandom;
      end
      send_sample(s, i == 303);
    end
  endtask

  task automatic test_random_windows();
    int phase;
    int items;
    int k;
    int eff;
    int len;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        k = 1;
      end else if (phase == 1) begin
        k = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(17, 40);
      end else begin
        k = $urandom_range(2, 16);
      end
      wait_drained();
      write_window(CfgW'(k));
      eff   = (k == 0) ? 1 : k;
      items = 0;
      while (items < 50) begin
        if ($urandom_range(0, 6) == 0) begin
          len = $urandom_range(1, eff);
        end else begin
          len = eff + $urandom_range(0, eff + 8);
        end
        send_sequence(len, 1'b1);
        items += len;
      end
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_window(CfgW'(3));
    long_hold_req = 1'b1;
    send_sequence(40, 1'b1);
    send_sequence(40, 1'b1);
    wait_drained();
  endtask

  task automatic test_no_idling();
    int items;
    wait_drained();
    idle_en = 1'b0;
    write_window(CfgW'($urandom_range(1, 8)));
    items = 0;
    while (items < 150) begin
      send_sequence(12, 1'b1);
      items += 12;
    end
  endtask

  initial begin : drive_out_stall
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < LongHold; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : check_results
    extremes_t want;
    forever begin
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (expected_extremes.size() == 0) begin
          $error("Result transaction with no expectation: min %0d, max %0d",
                 window_min_o, window_max_o);
          n_errors++;
        end else begin
          want = expected_extremes.pop_front();
          if (window_min_o !== want.lo) begin
            $error("window_min: expected %0d, got %0d", want.lo, window_min_o);
            n_errors++;
          end
          if (window_max_o !== want.hi) begin
            $error("window_max: expected %0d, got %0d", want.hi, window_max_o);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StuckLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_short_sequence();
    test_zero_window();
    test_midsequence_write();
    test_full_window();
    test_random_windows();
    test_backpressure();
    test_no_idling();
    wait_drained();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swmm_pkg.sv
sv/swmm_ram.sv
sv/swmm_deque.sv
sv/sliding_window_min_max_top.sv
dv/sliding_window_min_max_top_tb.sv
